[rtl/gibs_pkg.sv]
// Shared constants, types and helper functions for the greedy IoU box suppression block.
// No dependencies; imported by greedy_iou_box_suppression.
`default_nettype none
package gibs_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int CB         = 16;                        // stored corner width
    localparam int IW         = $clog2(MAX_BOXES);         // box index width
    localparam int CW         = $clog2(MAX_BOXES + 1);     // box count width
    localparam int AW         = 2 * CB;                    // area width
    localparam int UW         = AW + 1;                    // union width
    localparam int PW         = UW + 16;                   // compare width

    // configuration register indexes
    localparam logic REG_THR  = 1'b0;
    localparam logic REG_KEEP = 1'b1;

    typedef logic [CB-1:0] t_coord;

    typedef struct packed {
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
    } t_box;

    // Width of an interval, zero when inverted.
    function automatic t_coord span(input t_coord lo, input t_coord hi);
        span = (hi > lo) ? t_coord'(hi - lo) : '0;
    endfunction

    function automatic t_coord cmax(input t_coord a, input t_coord b);
        cmax = (a > b) ? a : b;
    endfunction

    function automatic t_coord cmin(input t_coord a, input t_coord b);
        cmin = (a < b) ? a : b;
    endfunction

endpackage
`default_nettype wire

[rtl/greedy_iou_box_suppression.sv]
// Top level of the greedy IoU box suppression block: box store, pick search,
// pipelined IoU check and result emission. Depends on gibs_pkg.
//
//  channel   direction  handshake                   payload
//  box       in         i_box_valid / o_box_ready   i_box_x1..y2, i_box_score, i_last_box
//  kept      out        o_kept_valid / i_kept_ready o_kept_index..o_overflowed
//  config    in         APB psel/penable/pwrite     paddr, pwdata, prdata
//
// Boxes load at one item per cycle in the load state. After the last box of n,
// each pick makes one pass over the score memory to find the best open box,
// then one pass over the corner memory through the IoU pipeline. Each kept item
// is read from the pick list and box memory and held until taken. No item is
// taken from the end of a set until all its kept items leave. Reset is synchronous.
`default_nettype none
module greedy_iou_box_suppression import gibs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_box_valid,
    output logic             o_box_ready,
    input  wire logic [15:0] i_box_x1,
    input  wire logic [15:0] i_box_y1,
    input  wire logic [15:0] i_box_x2,
    input  wire logic [15:0] i_box_y2,
    input  wire logic [15:0] i_box_score,
    input  wire logic        i_last_box,
    output logic             o_kept_valid,
    input  wire logic        i_kept_ready,
    output logic [5:0]       o_kept_index,
    output logic [15:0]      o_kept_x1,
    output logic [15:0]      o_kept_y1,
    output logic [15:0]      o_kept_x2,
    output logic [15:0]      o_kept_y2,
    output logic [15:0]      o_kept_score,
    output logic             o_last_kept,
    output logic             o_overflowed,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_PRD  = 4'd3;
    localparam logic [3:0] S_PLD  = 4'd4;
    localparam logic [3:0] S_PAR  = 4'd5;
    localparam logic [3:0] S_SUP  = 4'd6;
    localparam logic [3:0] S_EA   = 4'd7;
    localparam logic [3:0] S_EB   = 4'd8;
    localparam logic [3:0] S_EC   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]           r_state, n_state;
    logic [15:0]          r_thr;
    logic [6:0]           r_keep;
    logic [CW-1:0]        r_n;
    logic                 r_drop;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_nk;
    logic [CW-1:0]        r_k;
    logic [MAX_BOXES-1:0] r_open;

    // memories
    t_box                 r_cmem [MAX_BOXES];
    logic [15:0]          r_smem [MAX_BOXES];
    logic [IW-1:0]        r_lmem [MAX_BOXES];
    t_box                 r_cq;
    logic [15:0]          r_sq;
    logic [IW-1:0]        r_lq;
    logic [IW-1:0]        c_raddr;

    // search
    logic                 r_found;
    logic [15:0]          r_best;
    logic [IW-1:0]        r_pick;

    // pick box
    t_box                 r_pb;
    logic [CB-1:0]        r_pw, r_ph;
    logic [AW-1:0]        r_pa;

    // IoU pipeline
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [IW-1:0]        r_i1, r_i2, r_i3, r_i4;
    t_coord               r_ix, r_iy, r_bw, r_bh;
    logic [AW-1:0]        r_inter3, r_ab, r_inter4;
    logic [UW-1:0]        r_uni;
    logic                 c_sup;

    logic                 c_in_acc, c_issue, c_full;

    assign pready      = 1'b1;
    assign o_box_ready = (r_state == S_LOAD);
    assign c_in_acc    = i_box_valid && o_box_ready;
    assign c_full      = (r_n == CW'(MAX_BOXES));
    assign c_issue     = (r_cnt < r_n);

    // Read back configuration registers
    always_comb begin
        unique case (paddr[2])
            REG_THR:  prdata = {16'd0, r_thr};
            REG_KEEP: prdata = {25'd0, r_keep};
            default:  prdata = '0;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= 16'd26214;
            r_keep <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_THR) r_thr <= pwdata[15:0];
            else                     r_keep <= pwdata[6:0];
        end
    end

    // Select the shared read address of the box memories
    always_comb begin
        unique case (r_state)
            S_PRD:   c_raddr = r_pick;
            S_EB:    c_raddr = r_lq;
            default: c_raddr = r_cnt[IW-1:0];
        endcase
    end

    // Box memories: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (c_in_acc && !c_full) begin
            r_cmem[r_n[IW-1:0]] <= '{x1: CB'(i_box_x1), y1: CB'(i_box_y1),
                                     x2: CB'(i_box_x2), y2: CB'(i_box_y2)};
            r_smem[r_n[IW-1:0]] <= i_box_score;
        end
        r_cq <= r_cmem[c_raddr];
        r_sq <= r_smem[c_raddr];
    end

    // Pick list memory, kept boxes in pick order
    always_ff @(posedge i_clk) begin
        if (r_state == S_DEC && r_found) r_lmem[r_nk[IW-1:0]] <= r_pick;
        r_lq <= r_lmem[r_k[IW-1:0]];
    end

    // IoU datapath: spans, products, union, then the threshold compare
    always_ff @(posedge i_clk) begin
        r_ix     <= span(cmax(r_pb.x1, r_cq.x1), cmin(r_pb.x2, r_cq.x2));
        r_iy     <= span(cmax(r_pb.y1, r_cq.y1), cmin(r_pb.y2, r_cq.y2));
        r_bw     <= span(r_cq.x1, r_cq.x2);
        r_bh     <= span(r_cq.y1, r_cq.y2);
        r_i2     <= r_i1;
        r_inter3 <= r_ix * r_iy;
        r_ab     <= r_bw * r_bh;
        r_i3     <= r_i2;
        r_uni    <= UW'(r_pa) + UW'(r_ab) - UW'(r_inter3);
        r_inter4 <= r_inter3;
        r_i4     <= r_i3;
    end

    assign c_sup = (r_uni != '0) &&
                   ({1'b0, r_inter4, 16'd0} > (PW'(r_uni) * PW'(r_thr)));

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (c_in_acc && i_last_box) n_state = S_SRCH;
            S_SRCH: if (!c_issue && !r_v1) n_state = S_DEC;
            S_DEC: begin
                if (!r_found) n_state = S_EA;
                else if (r_keep != '0 && (7'(r_nk) + 7'd1) >= r_keep) n_state = S_EA;
                else n_state = S_PRD;
            end
            S_PRD:  n_state = S_PLD;
            S_PLD:  n_state = S_PAR;
            S_PAR:  n_state = S_SUP;
            S_SUP:  if (!c_issue && !r_v1 && !r_v2 && !r_v3 && !r_v4) n_state = S_SRCH;
            S_EA:   n_state = S_EB;
            S_EB:   n_state = S_EC;
            S_EC:   n_state = S_OUT;
            S_OUT: begin
                if (i_kept_ready) n_state = (r_k == r_nk) ? S_LOAD : S_EA;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_n          <= '0;
            r_drop       <= 1'b0;
            r_cnt        <= '0;
            r_nk         <= '0;
            r_k          <= '0;
            r_open       <= '0;
            r_found      <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            o_kept_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v1    <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    // store or drop the item, start the set on the last one
                    if (c_in_acc) begin
                        if (c_full) r_drop <= 1'b1;
                        else        r_n <= r_n + 1'b1;
                        if (i_last_box) begin
                            r_open  <= '1;
                            r_cnt   <= '0;
                            r_nk    <= '0;
                            r_found <= 1'b0;
                        end
                    end
                end
                S_SRCH: begin
                    // walk the scores, keep the best open box, ties to earlier
                    if (c_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_v1  <= 1'b1;
                        r_i1  <= r_cnt[IW-1:0];
                    end
                    if (r_v1 && r_open[r_i1] && (!r_found || r_sq > r_best)) begin
                        r_found <= 1'b1;
                        r_best  <= r_sq;
                        r_pick  <= r_i1;
                    end
                end
                S_DEC: begin
                    if (r_found) begin
                        r_open[r_pick] <= 1'b0;
                        r_nk           <= r_nk + 1'b1;
                    end
                    r_k <= '0;
                end
                S_PLD: begin
                    r_pb <= r_cq;
                    r_pw <= span(r_cq.x1, r_cq.x2);
                    r_ph <= span(r_cq.y1, r_cq.y2);
                end
                S_PAR: begin
                    r_pa  <= r_pw * r_ph;
                    r_cnt <= '0;
                end
                S_SUP: begin
                    // stream every box through the IoU pipeline
                    if (c_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_v1  <= 1'b1;
                        r_i1  <= r_cnt[IW-1:0];
                    end
                    if (r_v4 && c_sup) r_open[r_i4] <= 1'b0;
                    if (n_state == S_SRCH) begin
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                    end
                end
                S_EC: begin
                    o_kept_valid <= 1'b1;
                    o_kept_index <= 6'(r_lq);
                    o_kept_x1    <= 16'(r_cq.x1);
                    o_kept_y1    <= 16'(r_cq.y1);
                    o_kept_x2    <= 16'(r_cq.x2);
                    o_kept_y2    <= 16'(r_cq.y2);
                    o_kept_score <= r_sq;
                    o_last_kept  <= ((r_k + 1'b1) == r_nk);
                    o_overflowed <= r_drop;
                    r_k          <= r_k + 1'b1;
                end
                S_OUT: begin
                    // hold the item until taken, close the set after the last
                    if (i_kept_ready) begin
                        o_kept_valid <= 1'b0;
                        if (r_k == r_nk) begin
                            r_n    <= '0;
                            r_drop <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_kept_valid |-> (r_state == S_OUT))
        else $error("kept item shown outside the output state");
    a_pick_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && r_found) |-> r_open[r_pick])
        else $error("picked box is not open");
    a_nk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_nk <= r_n))
        else $error("more picks than stored boxes");
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_kept_ready && r_k == r_nk) |=> (r_n == '0 && !r_drop))
        else $error("set state not cleared after last kept item");
`endif

endmodule
`default_nettype wire
